[rtl/bshsm_pkg.sv]
// ----------------------------------------------------------------------------
// Bright star mask package
// Shared codes, constants and types for the bright star halo and trail mask.
// ----------------------------------------------------------------------------
package bshsm_pkg;

    localparam int POS_W = 24;
    localparam int MAG_W = 16;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HALO_SLOPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALO_MAG0    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VTRAIL_SLOPE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VTRAIL_MAG0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VTRAIL_WIDTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HTRAIL_SLOPE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HTRAIL_MAG0  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HTRAIL_WIDTH = 3'd7;

    localparam logic signed [MAG_W-1:0] MAG_FLOOR = -16'sd1000;
    localparam logic [9:0] MILLI = 10'd1000;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [MAG_W-1:0] mag;
    } t_ref_entry;

endpackage

[rtl/bright_star_halo_spike_mask_core.sv]
// ----------------------------------------------------------------------------
// Bright star halo and trail mask
// Stores reference stars in one memory and tests each query star against all
// of them for a round halo, a vertical trail and a horizontal trail.
// ----------------------------------------------------------------------------
// A clear or a load leaves the block idle and ready for the next item. A
// query occupies the block until all stored reference stars have been read
// and compared: the single read port of the reference memory delivers one
// star per cycle into a four stage compare pipeline, and the result then
// goes to an output register that holds it until its transfer. The memory
// needs no clearing pass after reset, since only entries below the fill
// count are ever read.
module bright_star_halo_spike_mask_core
    import bshsm_pkg::*;
#(
    parameter int REF_DEPTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [MODE_W-1:0]           i_mode,
    input  logic signed [POS_W-1:0]     i_pos_x,
    input  logic signed [POS_W-1:0]     i_pos_y,
    input  logic signed [MAG_W-1:0]     i_magnitude,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_marked,
    output logic                        o_table_overflow
);

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CW = $clog2(REF_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    function automatic logic [15:0] pos_len_base(input logic signed [MAG_W-1:0] mag,
                                                 input logic signed [MAG_W-1:0] mag0);
        logic signed [MAG_W:0] diff;
        diff = {mag[MAG_W-1], mag} - {mag0[MAG_W-1], mag0};
        return (diff > 0) ? diff[15:0] : 16'd0;
    endfunction

    function automatic logic [POS_W:0] abs_diff(input logic signed [POS_W-1:0] a,
                                                input logic signed [POS_W-1:0] b);
        logic signed [POS_W:0] diff;
        diff = {a[POS_W-1], a} - {b[POS_W-1], b};
        return diff[POS_W] ? -diff : diff;
    endfunction

    logic [CFG_W-1:0]        r_halo_slope, r_vtrail_slope, r_vtrail_width;
    logic [CFG_W-1:0]        r_htrail_slope, r_htrail_width;
    logic signed [MAG_W-1:0] r_halo_mag0, r_vtrail_mag0, r_htrail_mag0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_halo_slope   <= '0;
            r_halo_mag0    <= '0;
            r_vtrail_slope <= '0;
            r_vtrail_mag0  <= '0;
            r_vtrail_width <= '0;
            r_htrail_slope <= '0;
            r_htrail_mag0  <= '0;
            r_htrail_width <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALO_SLOPE:   r_halo_slope   <= i_cfg_data;
                REG_HALO_MAG0:    r_halo_mag0    <= i_cfg_data;
                REG_VTRAIL_SLOPE: r_vtrail_slope <= i_cfg_data;
                REG_VTRAIL_MAG0:  r_vtrail_mag0  <= i_cfg_data;
                REG_VTRAIL_WIDTH: r_vtrail_width <= i_cfg_data;
                REG_HTRAIL_SLOPE: r_htrail_slope <= i_cfg_data;
                REG_HTRAIL_MAG0:  r_htrail_mag0  <= i_cfg_data;
                REG_HTRAIL_WIDTH: r_htrail_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_ovf, n_ovf;
    logic [CW-1:0]           r_rd_idx, n_rd_idx;
    logic                    r_hit, n_hit;
    logic                    r_out_valid, n_out_valid;
    logic                    r_marked, n_marked;
    logic                    r_out_ovf, n_out_ovf;
    logic signed [POS_W-1:0] r_qx, r_qy;
    logic                    r_v1, r_v2, r_v3, r_v4;

    logic       accept;
    logic       rd_en;
    logic       wr_en;
    t_ref_entry wr_data;
    logic       table_full;
    logic       pipe_busy;
    logic       halo_hit;

    assign accept     = i_in_valid && o_in_ready;
    assign table_full = (r_count == CW'(REF_DEPTH));
    assign rd_en      = (r_state == ST_RUN) && (r_rd_idx < r_count);
    assign pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign wr_en      = accept && (i_mode == MODE_LOAD) && !table_full;

    always_comb begin
        wr_data.x   = i_pos_x;
        wr_data.y   = i_pos_y;
        wr_data.mag = (i_magnitude < MAG_FLOOR) ? MAG_FLOOR : i_magnitude;
    end

    // Loads are written only while idle and a query reads only after its own
    // transfer, so a write and a read of the same entry never overlap.
    t_ref_entry r_mem [REF_DEPTH];
    t_ref_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_count[AW-1:0]] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    logic [POS_W:0] r_ax, r_ay;
    logic [15:0]    r_dh, r_dv, r_dhz;
    logic [POS_W+10:0] r_sx, r_sy;
    logic [31:0]    r_len_h, r_len_v, r_len_hz;
    logic           r_axlt, r_aylt;
    logic           r_pre, r_vhit, r_hhit;
    logic [63:0]    r_a2, r_b2, r_r2;
    logic [64:0]    sq_sum;

    always_ff @(posedge i_clk) begin
        r_ax  <= abs_diff(r_rd_data.x, r_qx);
        r_ay  <= abs_diff(r_rd_data.y, r_qy);
        r_dh  <= pos_len_base(r_rd_data.mag, r_halo_mag0);
        r_dv  <= pos_len_base(r_rd_data.mag, r_vtrail_mag0);
        r_dhz <= pos_len_base(r_rd_data.mag, r_htrail_mag0);

        r_sx     <= r_ax * MILLI;
        r_sy     <= r_ay * MILLI;
        r_len_h  <= r_halo_slope * r_dh;
        r_len_v  <= r_vtrail_slope * r_dv;
        r_len_hz <= r_htrail_slope * r_dhz;
        r_axlt   <= r_ax < {{(POS_W+1-CFG_W){1'b0}}, r_vtrail_width};
        r_aylt   <= r_ay < {{(POS_W+1-CFG_W){1'b0}}, r_htrail_width};

        r_pre  <= (r_sx < {3'b000, r_len_h}) && (r_sy < {3'b000, r_len_h});
        r_vhit <= r_axlt && (r_sy < {3'b000, r_len_v});
        r_hhit <= r_aylt && (r_sx < {3'b000, r_len_hz});
        r_a2   <= r_sx[31:0] * r_sx[31:0];
        r_b2   <= r_sy[31:0] * r_sy[31:0];
        r_r2   <= r_len_h * r_len_h;
    end

    assign sq_sum   = {1'b0, r_a2} + {1'b0, r_b2};
    assign halo_hit = r_pre && (sq_sum < {1'b0, r_r2});

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_rd_idx    = r_rd_idx;
        n_hit       = r_hit;
        n_out_valid = r_out_valid && !i_out_ready;
        n_marked    = r_marked;
        n_out_ovf   = r_out_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_ovf   = 1'b0;
                        end
                        MODE_LOAD: begin
                            if (table_full) begin
                                n_ovf = 1'b1;
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_QUERY: begin
                            n_rd_idx = '0;
                            n_hit    = 1'b0;
                            n_state  = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                if (rd_en) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (r_v4) begin
                    n_hit = r_hit || halo_hit || r_vhit || r_hhit;
                end
                if (!rd_en && !pipe_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_marked    = r_hit;
                    n_out_ovf   = r_ovf;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_idx    <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_rd_idx    <= n_rd_idx;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
            r_v1        <= rd_en;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_marked  <= n_marked;
        r_out_ovf <= n_out_ovf;
        if (accept) begin
            r_qx <= i_pos_x;
            r_qy <= i_pos_y;
        end
    end

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_marked         = r_marked;
    assign o_table_overflow = r_out_ovf;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(REF_DEPTH))
        else $error("reference count exceeds the table depth");

    a_pipe_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3 || r_v4) |-> (r_state == ST_RUN))
        else $error("compare pipeline active outside a query");

    a_rd_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rd_idx <= r_count))
        else $error("read index passed the fill count");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> ($past(r_count) == CW'(REF_DEPTH)))
        else $error("overflow flag set while the table had room");

endmodule
